// File: rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg : shared types and constants of the HSV to RGB converter
// Field widths, fixed-point constants, sector codes and stage payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv_pkg;

   // Field widths
   localparam int HUE_W  = 16;  // degrees with 6 fraction bits
   localparam int HWR_W  = 15;  // wrapped hue, below one full turn
   localparam int CH_W   = 9;   // 0..256, 256 means 1.0
   localparam int REM_W  = 12;  // remainder inside one sector
   localparam int FRAC_W = 8;   // sector fraction in units of 1/256
   localparam int K_W    = 17;  // 65536 - s*x, 0..65536

   // Fixed-point constants
   localparam int HUE_FULL_TURN = 23040;  // 360 degrees
   localparam int HUE_SECTOR    = 3840;   // 60 degrees
   localparam int UNIT          = 256;    // 1.0 on a channel
   localparam int UNIT_SQ       = 65536;  // 1.0 on a product of two channels

   // Reciprocal of 15: floor(rem / 15) == (rem * RECIP_15) >> RECIP_SHIFT
   // for every rem below one sector
   localparam int RECIP_15    = 4370;
   localparam int RECIP_SHIFT = 16;
   localparam int RPROD_W     = REM_W + 13;

   // Six-sector codes
   typedef enum logic [2:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } sector_type;

   // Payload after the hue reduction stage
   typedef struct packed {
      sector_type        sector;
      logic [REM_W-1:0]  rem;
      logic [CH_W-1:0]   sat;
      logic [CH_W-1:0]   val;
      logic              gray;
   } s1_type;

   // Payload after the fraction stage
   typedef struct packed {
      sector_type        sector;
      logic [FRAC_W-1:0] frac;
      logic [CH_W-1:0]   sat;
      logic [CH_W-1:0]   val;
      logic [CH_W-1:0]   p;
      logic              gray;
   } s2_type;

   // Payload after the scale factor stage
   typedef struct packed {
      sector_type        sector;
      logic [CH_W-1:0]   val;
      logic [CH_W-1:0]   p;
      logic [K_W-1:0]    q_k;
      logic [K_W-1:0]    t_k;
      logic              gray;
   } s3_type;

   // Result color
   typedef struct packed {
      logic [CH_W-1:0]   red;
      logic [CH_W-1:0]   green;
      logic [CH_W-1:0]   blue;
   } rgb_type;

endpackage

`default_nettype wire

// File: rtl/hsv_if.sv
// ----------------------------------------------------------------------------
// hsv_if : request and response channels of the HSV to RGB converter
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsv_req_if;
   import hsv_pkg::*;

   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [CH_W-1:0]   saturation;
   logic [CH_W-1:0]   brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

interface hsv_rsp_if;
   import hsv_pkg::*;

   logic              valid;
   logic              ready;
   logic [CH_W-1:0]   red;
   logic [CH_W-1:0]   green;
   logic [CH_W-1:0]   blue;

   modport source (output valid, output red, output green, output blue,
                   input ready);
   modport sink   (input valid, input red, input green, input blue,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/hsv_reduce.sv
// ----------------------------------------------------------------------------
// hsv_reduce : first pipeline stage
// Clamps saturation and brightness, sends a hue of a full turn or more to
// zero, and splits the hue into a sector and a remainder inside that sector.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_reduce (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [hsv_pkg::HUE_W-1:0]     in_hue,
   input  logic [hsv_pkg::CH_W-1:0]      in_sat,
   input  logic [hsv_pkg::CH_W-1:0]      in_val,
   output logic                          out_valid,
   input  logic                          out_ready,
   output hsv_pkg::s1_type               out_data
);
   import hsv_pkg::*;

   localparam logic [CH_W-1:0]  UNIT_C = CH_W'(UNIT);
   localparam logic [HWR_W-1:0] SEC1   = HWR_W'(1 * HUE_SECTOR);
   localparam logic [HWR_W-1:0] SEC2   = HWR_W'(2 * HUE_SECTOR);
   localparam logic [HWR_W-1:0] SEC3   = HWR_W'(3 * HUE_SECTOR);
   localparam logic [HWR_W-1:0] SEC4   = HWR_W'(4 * HUE_SECTOR);
   localparam logic [HWR_W-1:0] SEC5   = HWR_W'(5 * HUE_SECTOR);

   logic             valid_ff;
   s1_type           data_ff;
   s1_type           data_in;
   logic [HWR_W-1:0] hue_w;
   logic [HWR_W-1:0] base;

   // Zero a hue of a full turn or more, clamp the channels, pick the sector by range compares
   always_comb begin
      data_in.sat  = (in_sat > UNIT_C) ? UNIT_C : in_sat;
      data_in.val  = (in_val > UNIT_C) ? UNIT_C : in_val;
      data_in.gray = (in_sat == '0);
      hue_w = (in_hue >= HUE_W'(HUE_FULL_TURN)) ? '0 : in_hue[HWR_W-1:0];
      if (hue_w >= SEC5) begin
         data_in.sector = SEC_MAGENTA;
         base           = SEC5;
      end else if (hue_w >= SEC4) begin
         data_in.sector = SEC_BLUE;
         base           = SEC4;
      end else if (hue_w >= SEC3) begin
         data_in.sector = SEC_CYAN;
         base           = SEC3;
      end else if (hue_w >= SEC2) begin
         data_in.sector = SEC_GREEN;
         base           = SEC2;
      end else if (hue_w >= SEC1) begin
         data_in.sector = SEC_YELLOW;
         base           = SEC1;
      end else begin
         data_in.sector = SEC_RED;
         base           = '0;
      end
      data_in.rem = REM_W'(hue_w - base);
   end

   // Advance when the stage is empty or its content moves on
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: rtl/hsv_frac.sv
// ----------------------------------------------------------------------------
// hsv_frac : second pipeline stage
// Turns the sector remainder into an 8-bit fraction and forms p = v(1-s).
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_frac (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  hsv_pkg::s1_type               in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output hsv_pkg::s2_type               out_data
);
   import hsv_pkg::*;

   localparam int PP_W = 2 * CH_W;

   logic               valid_ff;
   s2_type             data_ff;
   s2_type             data_in;
   logic [RPROD_W-1:0] rprod;
   logic [PP_W-1:0]    pprod;

   // Divide the remainder by 15 through its reciprocal; scale v by 1-s
   always_comb begin
      rprod = RPROD_W'(in_data.rem) * RPROD_W'(RECIP_15);
      pprod = PP_W'(in_data.val) * (PP_W'(UNIT) - PP_W'(in_data.sat));
      data_in.sector = in_data.sector;
      data_in.frac   = rprod[RECIP_SHIFT +: FRAC_W];
      data_in.sat    = in_data.sat;
      data_in.val    = in_data.val;
      data_in.p      = pprod[8 +: CH_W];
      data_in.gray   = in_data.gray;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: rtl/hsv_scale.sv
// ----------------------------------------------------------------------------
// hsv_scale : third pipeline stage
// Forms the scale factors 1-s*f and 1-s(1-f) in units of 1/65536.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  hsv_pkg::s2_type               in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output hsv_pkg::s3_type               out_data
);
   import hsv_pkg::*;

   localparam int SP_W = K_W + 1;

   logic            valid_ff;
   s3_type          data_ff;
   s3_type          data_in;
   logic [SP_W-1:0] sf;
   logic [SP_W-1:0] sfc;

   // Both products stay at or below 65536, so the differences fit K_W bits
   always_comb begin
      sf  = SP_W'(in_data.sat) * SP_W'(in_data.frac);
      sfc = SP_W'(in_data.sat) * (SP_W'(UNIT) - SP_W'(in_data.frac));
      data_in.sector = in_data.sector;
      data_in.val    = in_data.val;
      data_in.p      = in_data.p;
      data_in.q_k    = K_W'(SP_W'(UNIT_SQ) - sf);
      data_in.t_k    = K_W'(SP_W'(UNIT_SQ) - sfc);
      data_in.gray   = in_data.gray;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: rtl/hsv_mix.sv
// ----------------------------------------------------------------------------
// hsv_mix : last pipeline stage and output register
// Forms q and t, then routes v, p, q and t to the channels by sector.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_mix (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  hsv_pkg::s3_type               in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output hsv_pkg::rgb_type              out_data
);
   import hsv_pkg::*;

   localparam int QP_W = CH_W + K_W;

   logic            valid_ff;
   rgb_type         data_ff;
   rgb_type         data_in;
   logic [QP_W-1:0] qprod;
   logic [QP_W-1:0] tprod;
   logic [CH_W-1:0] q;
   logic [CH_W-1:0] t;
   logic [CH_W-1:0] v;
   logic [CH_W-1:0] p;

   // Scale v by the factors and keep the integer part
   always_comb begin
      qprod = QP_W'(in_data.val) * QP_W'(in_data.q_k);
      tprod = QP_W'(in_data.val) * QP_W'(in_data.t_k);
      q     = qprod[16 +: CH_W];
      t     = tprod[16 +: CH_W];
      v     = in_data.val;
      p     = in_data.p;
   end

   // Six-sector channel table; gray passes brightness to every channel
   always_comb begin
      if (in_data.gray) begin
         data_in = '{red: v, green: v, blue: v};
      end else begin
         case (in_data.sector)
            SEC_RED:    data_in = '{red: v, green: t, blue: p};
            SEC_YELLOW: data_in = '{red: q, green: v, blue: p};
            SEC_GREEN:  data_in = '{red: p, green: v, blue: t};
            SEC_CYAN:   data_in = '{red: p, green: q, blue: v};
            SEC_BLUE:   data_in = '{red: t, green: p, blue: v};
            default:    data_in = '{red: v, green: p, blue: q};
         endcase
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: rtl/hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit : HSV to RGB color converter
// Four-stage pipeline converting one HSV color to RGB per transfer.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                          | transfer
//   --------+-----+----------------------------------+--------------------
//   req     | in  | hue[15:0] sat[8:0] bright[8:0]   | req.valid & ready
//   rsp     | out | red[8:0] green[8:0] blue[8:0]    | rsp.valid & ready
//
// One color enters per clock while rsp takes results; it passes the stage registers in order to rsp.
// Stages: hue reduction, fraction and p, scale factors, q/t and channel mux.
// The last stage is the output register.
// Reset empties every stage; payload registers keep their contents.
// A stage takes a new transfer when it is empty or its content moves on,
// so a stall on rsp fills bubbles first and then holds req off.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_unit (
   input  logic        clock,
   input  logic        reset,
   hsv_req_if.sink     req,
   hsv_rsp_if.source   rsp
);
   import hsv_pkg::*;

   logic    s1_valid;
   logic    s1_ready;
   s1_type  s1_data;
   logic    s2_valid;
   logic    s2_ready;
   s2_type  s2_data;
   logic    s3_valid;
   logic    s3_ready;
   s3_type  s3_data;
   rgb_type rgb;

   hsv_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_hue    (req.hue),
      .in_sat    (req.saturation),
      .in_val    (req.brightness),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   hsv_frac u_frac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   hsv_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   hsv_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rgb)
   );

   // Drive the response payload from the output register
   assign rsp.red   = rgb.red;
   assign rsp.green = rgb.green;
   assign rsp.blue  = rgb.blue;

endmodule

`default_nettype wire

// File: rtl/hsv_checker.sv
// ----------------------------------------------------------------------------
// hsv_checker : port-level assertions for the HSV to RGB converter
// Watches the request and response channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_ready,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [hsv_pkg::CH_W-1:0]  rsp_red,
   input  logic [hsv_pkg::CH_W-1:0]  rsp_green,
   input  logic [hsv_pkg::CH_W-1:0]  rsp_blue
);
   import hsv_pkg::*;

   localparam logic [CH_W-1:0] UNIT_C = CH_W'(UNIT);

   // Hold a stalled response until it transfers
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A draining output never holds off requests
   a_ready_flow: assert property (@(posedge clock)
      rsp_ready |-> req_ready)
      else $error("request held off while response drains");

   // Keep every channel within 0..1.0
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red <= UNIT_C) && (rsp_green <= UNIT_C) && (rsp_blue <= UNIT_C))
      else $error("channel above full scale");

endmodule

bind hsv_to_rgb_converter_unit hsv_checker u_hsv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_red   (rsp.red),
   .rsp_green (rsp.green),
   .rsp_blue  (rsp.blue)
);

`default_nettype wire

// File: tb/hsv_to_rgb_converter_unit_checker.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit_checker : result checker of the HSV to RGB unit
// Watches both channels, predicts the RGB color of every accepted HSV
// transfer and compares each response transfer with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_unit_checker (
   input  logic  clock,
   input  logic  reset,
   hsv_req_if    req,
   hsv_rsp_if    rsp,
   output int    fail_count,
   output int    pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   import hsv_pkg::*;

   localparam int REPORT_LIMIT = 10;

   rgb_type expected_colors[$];
   int      fail_total    = 0;
   int      pending_total = 0;

   assign fail_count    = fail_total;
   assign pending_count = pending_total;

   // Six-sector HSV to RGB conversion on 0..256 channels
   function automatic rgb_type hsv_color_to_rgb(input logic [HUE_W-1:0] hue,
                                                input logic [CH_W-1:0]  sat_in,
                                                input logic [CH_W-1:0]  bri_in);
      int unsigned h, s, v, frac, p, q, t;
      sector_type  sector;
      rgb_type     color;
      s = (sat_in > UNIT) ? UNIT : sat_in;
      v = (bri_in > UNIT) ? UNIT : bri_in;
      if (s == 0) begin
         color.red   = CH_W'(v);
         color.green = CH_W'(v);
         color.blue  = CH_W'(v);
      end else begin
         h = hue;
         // wrap a full turn or more back to red
         if (h >= HUE_FULL_TURN) begin
            h = 0;
         end
         sector = sector_type'(h / HUE_SECTOR);
         frac   = (h % HUE_SECTOR) / (HUE_SECTOR / UNIT);
         p      = (v * (UNIT - s)) >> FRAC_W;
         q      = (v * (UNIT_SQ - s * frac)) >> (2 * FRAC_W);
         t      = (v * (UNIT_SQ - s * (UNIT - frac))) >> (2 * FRAC_W);
         case (sector)
            SEC_RED: begin
               color = '{CH_W'(v), CH_W'(t), CH_W'(p)};
            end
            SEC_YELLOW: begin
               color = '{CH_W'(q), CH_W'(v), CH_W'(p)};
            end
            SEC_GREEN: begin
               color = '{CH_W'(p), CH_W'(v), CH_W'(t)};
            end
            SEC_CYAN: begin
               color = '{CH_W'(p), CH_W'(q), CH_W'(v)};
            end
            SEC_BLUE: begin
               color = '{CH_W'(t), CH_W'(p), CH_W'(v)};
            end
            default: begin
               color = '{CH_W'(v), CH_W'(p), CH_W'(q)};
            end
         endcase
      end
      return color;
   endfunction

   // Record predictions and compare results at each rising edge
   always @(posedge clock) begin : watch_channels
      rgb_type want;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            if (expected_colors.size() == 0) begin
               fail_total++;
               if (fail_total <= REPORT_LIMIT) begin
                  $display("%t: unexpected result red %0d green %0d blue %0d",
                           $realtime, rsp.red, rsp.green, rsp.blue);
               end
            end else begin
               want = expected_colors.pop_front();
               if (rsp.red !== want.red || rsp.green !== want.green ||
                   rsp.blue !== want.blue) begin
                  fail_total++;
                  if (fail_total <= REPORT_LIMIT) begin
                     $display("%t: mismatch expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                              $realtime, want.red, want.green, want.blue,
                              rsp.red, rsp.green, rsp.blue);
                  end
               end
            end
         end
         if (req.valid && req.ready) begin
            expected_colors.push_back(hsv_color_to_rgb(req.hue, req.saturation,
                                                       req.brightness));
         end
         pending_total = expected_colors.size();
      end
   end

endmodule

`default_nettype wire

// File: tb/hsv_to_rgb_converter_unit_test.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit_test : testbench of the HSV to RGB converter
// Drives directed corner colors and then random bursts of HSV colors with
// random gaps, stalls the response side on a changing pattern and once for
// a long stretch, and lets the checker compare every result.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   import hsv_pkg::*;

   localparam int RANDOM_COLORS    = 1150;
   localparam int LONG_HOLD_CYCLES = 48;
   localparam int DRAIN_CYCLES     = 12;
   localparam int RESET_CYCLES     = 12;

   logic clock     = 1'b0;
   logic reset     = 1'b1;
   logic long_hold = 1'b0;
   logic hold_done;
   int   fail_count;
   int   pending_count;

   hsv_req_if req ();
   hsv_rsp_if rsp ();

   hsv_to_rgb_converter_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   hsv_to_rgb_converter_unit_checker color_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .rsp           (rsp),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop in case the handshake hangs
   initial begin
      #5000000;
      $display("hsv_to_rgb_converter_unit_test NOT OK");
      $finish;
   end

   // Offer one color and hold it until the transfer
   task automatic send_color(input logic [HUE_W-1:0] hue,
                             input logic [CH_W-1:0]  sat,
                             input logic [CH_W-1:0]  bri);
      @(negedge clock);
      req.valid      = 1'b1;
      req.hue        = hue;
      req.saturation = sat;
      req.brightness = bri;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // Drop valid for a number of cycles, with junk on the payload
   task automatic rest_req(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req.valid      = 1'b0;
         req.hue        = HUE_W'($urandom);
         req.saturation = CH_W'($urandom);
         req.brightness = CH_W'($urandom);
      end
   endtask

   function automatic logic [HUE_W-1:0] random_hue();
      case ($urandom_range(0, 4))
         0:       return HUE_W'($urandom);
         1:       return HUE_W'($urandom_range(HUE_FULL_TURN - 1, 0));
         2:       return HUE_W'($urandom_range(5, 0) * HUE_SECTOR + $urandom_range(40, 0));
         3:       return HUE_W'(($urandom_range(6, 1) * HUE_SECTOR) - $urandom_range(40, 1));
         default: return HUE_W'($urandom_range(HUE_FULL_TURN - 1, 0));
      endcase
   endfunction

   // Bias channel values toward zero, full scale and the clipped range
   function automatic logic [CH_W-1:0] random_level();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return CH_W'(UNIT);
         2:       return CH_W'($urandom_range(511, UNIT + 1));
         3:       return CH_W'($urandom);
         default: return CH_W'($urandom_range(UNIT, 1));
      endcase
   endfunction

   // Response side: changing stall pattern, plus one long hold-off on request
   initial begin : rsp_drain
      logic [15:0] ready_mask;
      int          step;
      rsp.ready  = 1'b0;
      hold_done  = 1'b0;
      ready_mask = '1;
      step       = 0;
      forever begin
         @(negedge clock);
         if (long_hold && !hold_done) begin
            rsp.ready = 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            if (step == 0) begin
               ready_mask = ($urandom_range(0, 3) == 0) ? 16'hffff
                                                        : 16'($urandom) | 16'h0101;
            end
            rsp.ready = ready_mask[step % 16];
            step      = (step + 1) % 64;
         end
      end
   end

   // Stimulus and verdict
   initial begin : req_drive
      int   sent;
      int   burst;
      logic drained;
      req.valid      = 1'b0;
      req.hue        = '0;
      req.saturation = '0;
      req.brightness = '0;
      drained        = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Corners: sector edges, hue wrap, gray, clipped channels
      send_color(16'd0, 9'd256, 9'd256);
      send_color(16'd23039, 9'd256, 9'd256);
      send_color(16'd23040, 9'd200, 9'd256);
      send_color(16'hffff, 9'd256, 9'd200);
      send_color(16'd3839, 9'd256, 9'd256);
      send_color(16'd3840, 9'd128, 9'd256);
      send_color(16'd7680, 9'd256, 9'd100);
      send_color(16'd11520, 9'd256, 9'd256);
      send_color(16'd15360, 9'd77, 9'd256);
      send_color(16'd19200, 9'd256, 9'd256);
      send_color(16'd19199, 9'd1, 9'd255);
      send_color(16'd1000, 9'd0, 9'd256);
      send_color(16'd5000, 9'd0, 9'd0);
      send_color(16'd12000, 9'd0, 9'd511);
      send_color(16'd9000, 9'd511, 9'd511);
      send_color(16'd14000, 9'd257, 9'd257);
      send_color(16'd17000, 9'd300, 9'd0);
      send_color(16'd21000, 9'd256, 9'd0);
      send_color(16'd2000, 9'd1, 9'd1);
      send_color(16'd30000, 9'd100, 9'd100);
      send_color(16'd15, 9'd256, 9'd256);
      send_color(16'd14, 9'd256, 9'd256);
      send_color(16'd43690, 9'd170, 9'd341);
      rest_req(3);

      // Random bursts with random gaps
      sent = 0;
      while (sent < RANDOM_COLORS) begin
         // hold the response side off while the input keeps pushing
         if (sent >= 300 && !long_hold) begin
            long_hold = 1'b1;
            repeat (40) send_color(random_hue(), random_level(), random_level());
            sent += 40;
         end
         // drain the pipeline completely once
         if (sent >= 700 && !drained) begin
            rest_req(1);
            while (pending_count != 0) @(negedge clock);
            drained = 1'b1;
         end
         burst = $urandom_range(1, 24);
         repeat (burst) send_color(random_hue(), random_level(), random_level());
         sent += burst;
         if ($urandom_range(0, 3) != 0) begin
            rest_req($urandom_range(1, 10));
         end
      end

      // Wait for the last results, then for any stray ones
      rest_req(1);
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("hsv_to_rgb_converter_unit_test OK");
      end else begin
         $display("hsv_to_rgb_converter_unit_test NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
